// ===== sv/flow_pulse_rate_monitor_defines.svh =====
// Assertion macros used by the checker file of the flow pulse rate monitor.
`ifndef FLOW_PULSE_RATE_MONITOR_DEFINES_SVH
`define FLOW_PULSE_RATE_MONITOR_DEFINES_SVH

// The consequent must hold in the cycle after the antecedent.
`define FPRM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

// The property must hold at every clock edge out of reset.
`define FPRM_ASSERT_ALWAYS(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");

`endif

// ===== sv/fprm_pkg.sv =====
package fprm_pkg;

    // Event kinds carried in the input tuser.
    typedef enum logic [1:0] {
        OP_WRAP   = 2'd0,
        OP_PULSE  = 2'd1,
        OP_TICK   = 2'd2,
        OP_REPORT = 2'd3
    } t_opcode;

    // Configuration register indexes.
    localparam logic [2:0] CFG_PULSE_VOL  = 3'd0;
    localparam logic [2:0] CFG_WRAP_STEP  = 3'd1;
    localparam logic [2:0] CFG_MIN_WINDOW = 3'd2;
    localparam logic [2:0] CFG_NO_FLOW    = 3'd3;
    localparam logic [2:0] CFG_NO_TICKS   = 3'd4;
    localparam logic [2:0] CFG_OFF_FLOW   = 3'd5;
    localparam logic [2:0] CFG_OFF_TICKS  = 3'd6;

    // Register reset values.
    localparam logic [7:0]  RST_PULSE_VOL  = 8'd2;
    localparam logic [15:0] RST_WRAP_STEP  = 16'd65000;
    localparam logic [15:0] RST_MIN_WINDOW = 16'd300;
    localparam logic [15:0] RST_NO_FLOW    = 16'd500;
    localparam logic [15:0] RST_NO_TICKS   = 16'd300;
    localparam logic [15:0] RST_OFF_FLOW   = 16'd400;
    localparam logic [15:0] RST_OFF_TICKS  = 16'd250;

    // Divider: quotient width and index of the last step.
    localparam int DIV_W = 30;
    localparam logic [4:0] DIV_LAST = 5'(DIV_W - 1);

    // Reciprocal of 81 scaled by 2^37; exact for every dividend below 2^30.
    localparam logic [30:0] FLOW_RECIP = 31'd1696777204;
    localparam int FLOW_SHIFT = 37;

    // Stream widths.
    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 96;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MEASURE,
        ST_DIV_RATE,
        ST_RATE,
        ST_DIV_FLOW,
        ST_FLOW,
        ST_SUPERVISE,
        ST_DONE
    } t_state;

    // Saturating 16-bit increment.
    function automatic logic [15:0] bump16(input logic [15:0] v);
        return (v == 16'hFFFF) ? v : v + 16'd1;
    endfunction

endpackage

// ===== sv/flow_pulse_rate_monitor.sv =====
// Wrap, pulse and report beats go from ST_IDLE to ST_DONE; a stalled result beat holds ST_DONE.
// Rate tick with a window: ST_MEASURE, the 30-step pass of the divider in ST_DIV_RATE
// (count*1000 over the window), ST_RATE, a reciprocal multiply for the scaling by 81 in
// ST_DIV_FLOW, ST_FLOW and ST_SUPERVISE; a tick without a window skips to ST_SUPERVISE.
// The block takes one item at a time; the output register frees the next input beat early.
// Synchronous active-low reset restores register defaults and clears all measurement state.
module flow_pulse_rate_monitor
    import fprm_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Configuration write channel.
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [2:0]            i_cfg_index,
    input  logic [15:0]           i_cfg_data,
    // Input stream.
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // tdata: capture_value[15:0], inlet_open[16], zero[23:17]
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // tuser: opcode[1:0]
    input  logic [1:0]            s_axis_tuser,
    // Output stream.
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // tdata: flow_ml_per_min[31:0], pulse_rate_hz[63:32], no_water_flag[64],
    //        no_water_event[65], not_off_event[66], volume_ml[90:67],
    //        volume_valid[91], zero[95:92]
    output logic [OUT_DATA_W-1:0] m_axis_tdata
);

    // Control and measurement state.
    t_state      r_state, n_state;
    logic        r_ovalid, n_ovalid;
    logic [7:0]  r_pvol;
    logic [15:0] r_wrap, r_minwin, r_nfl, r_nft, r_ofl, r_oct;
    logic [31:0] r_time, n_time;
    logic [31:0] r_first, n_first;
    logic [31:0] r_last, n_last;
    logic [15:0] r_count, n_count;
    logic [31:0] r_vacc, n_vacc;
    logic [31:0] r_flow, n_flow;
    logic [31:0] r_rate, n_rate;
    logic [15:0] r_lft, n_lft;
    logic [15:0] r_ct, n_ct;
    logic        r_wm, n_wm;

    // Per-item working registers and the divider.
    logic        r_inlet, n_inlet;
    logic        r_nwe, n_nwe;
    logic        r_offe, n_offe;
    logic [23:0] r_rvol, n_rvol;
    logic        r_rvalid, n_rvalid;
    logic [DIV_W-1:0] r_dq, n_dq;
    logic [31:0] r_rem, n_rem;
    logic [31:0] r_dsr, n_dsr;
    logic [4:0]  r_cnt, n_cnt;
    logic [OUT_DATA_W-1:0] r_odata, n_odata;

    // Combinational helpers.
    logic [32:0] w_trial;
    logic        w_ge;
    logic [32:0] w_diff;
    logic [31:0] w_stamp;
    logic [31:0] w_window;
    logic [25:0] w_scaled_count;
    logic [DIV_W-1:0] w_flow_num;
    logic [60:0] w_recip;
    logic [39:0] w_prod;
    logic [15:0] w_low, w_closed;
    t_opcode     w_op;

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = (r_state == ST_IDLE);
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;
    assign w_op          = t_opcode'(s_axis_tuser);

    // One restoring division step: shift in the next dividend bit and try to subtract.
    assign w_trial = {r_rem, r_dq[DIV_W-1]};
    assign w_ge    = (w_trial >= {1'b0, r_dsr});
    assign w_diff  = w_trial - {1'b0, r_dsr};

    assign w_stamp        = r_time + 32'(s_axis_tdata[15:0]);
    assign w_window       = r_last - r_first;
    assign w_scaled_count = 26'(r_count) * 26'd1000;
    assign w_flow_num     = (r_dq + DIV_W'(5)) * DIV_W'(10);
    assign w_recip        = 61'(r_dq) * 61'(FLOW_RECIP);
    assign w_prod         = 40'(r_dq) * 40'd1000;
    assign w_low          = bump16(r_lft);
    assign w_closed       = bump16(r_ct);

    // Sequencer: next state, state updates and divider control.
    always_comb begin
        n_state  = r_state;
        n_ovalid = r_ovalid && !m_axis_tready;
        n_time   = r_time;
        n_first  = r_first;
        n_last   = r_last;
        n_count  = r_count;
        n_vacc   = r_vacc;
        n_flow   = r_flow;
        n_rate   = r_rate;
        n_lft    = r_lft;
        n_ct     = r_ct;
        n_wm     = r_wm;
        n_inlet  = r_inlet;
        n_nwe    = r_nwe;
        n_offe   = r_offe;
        n_rvol   = r_rvol;
        n_rvalid = r_rvalid;
        n_dq     = r_dq;
        n_rem    = r_rem;
        n_dsr    = r_dsr;
        n_cnt    = r_cnt;
        n_odata  = r_odata;

        case (r_state)
            ST_IDLE: begin
                if (s_axis_tvalid) begin
                    n_nwe    = 1'b0;
                    n_offe   = 1'b0;
                    n_rvol   = '0;
                    n_rvalid = 1'b0;
                    n_inlet  = s_axis_tdata[16];
                    n_state  = ST_DONE;
                    case (w_op)
                        OP_WRAP: begin
                            n_time = r_time + 32'(r_wrap);
                        end
                        OP_PULSE: begin
                            n_vacc = r_vacc + 32'(r_pvol);
                            if (r_first == '0) begin
                                n_first = w_stamp;
                            end
                            n_last  = w_stamp;
                            n_count = bump16(r_count);
                        end
                        OP_TICK: begin
                            n_state = ST_MEASURE;
                        end
                        OP_REPORT: begin
                            n_rvol   = r_vacc[23:0];
                            n_rvalid = (r_vacc != '0);
                            n_vacc   = '0;
                        end
                        default: begin
                            n_state = ST_DONE;
                        end
                    endcase
                end
            end

            // Close the window and start the rate division if there is one.
            ST_MEASURE: begin
                if (r_count <= 16'd1) begin
                    n_flow  = '0;
                    n_state = ST_SUPERVISE;
                end else begin
                    n_first = (w_window < 32'(r_minwin)) ? '0 : r_last;
                    n_last  = '0;
                    n_count = '0;
                    if (w_window == '0) begin
                        n_rate  = '0;
                        n_flow  = '0;
                        n_state = ST_SUPERVISE;
                    end else begin
                        n_dq    = DIV_W'(w_scaled_count);
                        n_rem   = '0;
                        n_dsr   = w_window;
                        n_cnt   = DIV_LAST;
                        n_state = ST_DIV_RATE;
                    end
                end
            end

            ST_DIV_RATE: begin
                n_rem = w_ge ? w_diff[31:0] : w_trial[31:0];
                n_dq  = {r_dq[DIV_W-2:0], w_ge};
                n_cnt = r_cnt - 5'd1;
                if (r_cnt == '0) begin
                    n_state = ST_RATE;
                end
            end

            // Store the rate and form the scaled rate for the division by 81.
            ST_RATE: begin
                n_rate  = 32'(r_dq);
                n_dq    = w_flow_num;
                n_state = ST_DIV_FLOW;
            end

            // Divide by 81 with a reciprocal multiply and a shift.
            ST_DIV_FLOW: begin
                n_dq    = DIV_W'(w_recip >> FLOW_SHIFT);
                n_state = ST_FLOW;
            end

            ST_FLOW: begin
                n_flow  = (w_prod[39:32] != '0) ? 32'hFFFF_FFFF : w_prod[31:0];
                n_state = ST_SUPERVISE;
            end

            // No-water supervision with the inlet open, valve-not-off check when closed.
            ST_SUPERVISE: begin
                if (r_inlet) begin
                    if (r_flow < 32'(r_nfl)) begin
                        if (w_low > r_nft) begin
                            n_wm  = 1'b1;
                            n_nwe = 1'b1;
                            n_lft = '0;
                        end else begin
                            n_lft = w_low;
                        end
                    end else begin
                        n_lft = '0;
                        n_wm  = 1'b0;
                    end
                end else begin
                    if (w_closed > r_oct) begin
                        n_offe = (r_flow > 32'(r_ofl));
                        n_ct   = '0;
                    end else begin
                        n_ct = w_closed;
                    end
                end
                n_state = ST_DONE;
            end

            // Hand the result to the output register once it is free.
            ST_DONE: begin
                if (!r_ovalid || m_axis_tready) begin
                    n_odata  = {4'd0, r_rvalid, r_rvol, r_offe, r_nwe, r_wm, r_rate, r_flow};
                    n_ovalid = 1'b1;
                    n_state  = ST_IDLE;
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // State register, configuration registers and measurement state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_ovalid <= 1'b0;
            r_pvol   <= RST_PULSE_VOL;
            r_wrap   <= RST_WRAP_STEP;
            r_minwin <= RST_MIN_WINDOW;
            r_nfl    <= RST_NO_FLOW;
            r_nft    <= RST_NO_TICKS;
            r_ofl    <= RST_OFF_FLOW;
            r_oct    <= RST_OFF_TICKS;
            r_time   <= '0;
            r_first  <= '0;
            r_last   <= '0;
            r_count  <= '0;
            r_vacc   <= '0;
            r_flow   <= '0;
            r_rate   <= '0;
            r_lft    <= '0;
            r_ct     <= '0;
            r_wm     <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
            r_time   <= n_time;
            r_first  <= n_first;
            r_last   <= n_last;
            r_count  <= n_count;
            r_vacc   <= n_vacc;
            r_flow   <= n_flow;
            r_rate   <= n_rate;
            r_lft    <= n_lft;
            r_ct     <= n_ct;
            r_wm     <= n_wm;
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_PULSE_VOL:  r_pvol   <= i_cfg_data[7:0];
                    CFG_WRAP_STEP:  r_wrap   <= i_cfg_data;
                    CFG_MIN_WINDOW: r_minwin <= i_cfg_data;
                    CFG_NO_FLOW:    r_nfl    <= i_cfg_data;
                    CFG_NO_TICKS:   r_nft    <= i_cfg_data;
                    CFG_OFF_FLOW:   r_ofl    <= i_cfg_data;
                    CFG_OFF_TICKS:  r_oct    <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
        end
    end

    // Working registers, divider and output payload.
    always_ff @(posedge i_clk) begin
        r_inlet  <= n_inlet;
        r_nwe    <= n_nwe;
        r_offe   <= n_offe;
        r_rvol   <= n_rvol;
        r_rvalid <= n_rvalid;
        r_dq     <= n_dq;
        r_rem    <= n_rem;
        r_dsr    <= n_dsr;
        r_cnt    <= n_cnt;
        r_odata  <= n_odata;
    end

endmodule

// ===== sv/fprm_checker.sv =====
`include "flow_pulse_rate_monitor_defines.svh"

module fprm_sva
    import fprm_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  s_axis_tvalid,
    input logic                  s_axis_tready,
    input logic                  m_axis_tvalid,
    input logic                  m_axis_tready,
    input logic [OUT_DATA_W-1:0] m_axis_tdata
);

    // Handshake and result fields used by the properties.
    logic w_stall;
    logic w_in_beat;
    logic w_dry;
    logic w_nw_evt;
    logic w_off_evt;
    logic w_vol_ok;
    logic w_evt_ok;

    assign w_stall   = m_axis_tvalid && !m_axis_tready;
    assign w_in_beat = s_axis_tvalid && s_axis_tready;
    assign w_dry     = m_axis_tdata[64];
    assign w_nw_evt  = m_axis_tdata[65];
    assign w_off_evt = m_axis_tdata[66];
    assign w_vol_ok  = m_axis_tdata[91];
    assign w_evt_ok  = !(w_nw_evt && w_off_evt) && !(w_vol_ok && (w_nw_evt || w_off_evt));

    // A stalled result beat holds its payload.
    `FPRM_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, w_stall, m_axis_tvalid && $stable(m_axis_tdata))

    // In the cycle after an input beat the block is still busy with that item.
    `FPRM_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, w_in_beat, !s_axis_tready)

    // The two tick events never come together, and neither comes with the report flag in one result.
    `FPRM_ASSERT_ALWAYS(a_event_excl, i_clk, i_rst_n, !m_axis_tvalid || w_evt_ok)

    // A raised no-water event goes with the latched flag.
    `FPRM_ASSERT_ALWAYS(a_event_flag, i_clk, i_rst_n, !(m_axis_tvalid && w_nw_evt) || w_dry)

endmodule

bind flow_pulse_rate_monitor fprm_sva u_fprm_sva (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
